[rtl/core/file_write_receiver_core_defines.svh]
// Assertion macros for the file write receiver core.
// Included by file_write_receiver_core.sv; needs no package.
`ifndef FILE_WRITE_RECEIVER_CORE_DEFINES_SVH
`define FILE_WRITE_RECEIVER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FWR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FWR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/fwr_pkg.sv]
// Shared types and constants of the file write receiver core.
// No dependencies; imported by all core modules.
`default_nettype none
package fwr_pkg;

   localparam int FWR_MAX_PACKET_BYTES = 256;
   localparam int FWR_QUEUE_DEPTH      = 4;
   localparam logic [15:0] FWR_ACK_INTERVAL_DEFAULT = 16'd10;

   localparam logic [31:0] FWR_TOTAL_BYTES_RESET  = 32'd0;
   localparam logic [31:0] FWR_START_OFFSET_RESET = 32'd0;

   typedef enum logic {
      FWR_OP_START = 1'b0,
      FWR_OP_DATA  = 1'b1
   } fwr_op_type;

   typedef enum logic [2:0] {
      FWR_ST_OK         = 3'd0,
      FWR_ST_BAD_STATE  = 3'd1,
      FWR_ST_BAD_SIZE   = 3'd2,
      FWR_ST_WRITE_FAIL = 3'd3,
      FWR_ST_COUNT_ERR  = 3'd4,
      FWR_ST_CKSUM_ERR  = 3'd5
   } fwr_status_type;

   typedef enum logic [1:0] {
      FWR_CSR_TOTAL_BYTES  = 2'd0,
      FWR_CSR_ACK_INTERVAL = 2'd1,
      FWR_CSR_CHECK_EN     = 2'd2,
      FWR_CSR_START_OFFSET = 2'd3
   } fwr_csr_type;

   typedef struct packed {
      logic [31:0] total_bytes;
      logic [15:0] ack_interval;
      logic        check_en;
      logic [31:0] start_offset;
   } fwr_cfg_type;

   // one queue entry: a start, or the end of a message
   typedef struct packed {
      logic        is_start;
      logic [31:0] sum;
      logic [31:0] seq_no;
      logic        sum_present;
      logic [15:0] sent_checksum;
      logic        write_ok;
      logic [31:0] transfer_tag;
   } fwr_msg_type;

   localparam int FWR_MSG_W = $bits(fwr_msg_type);

endpackage
`default_nettype wire

[rtl/core/fwr_channels.sv]
// Word channel interfaces of the file write receiver core.
// Request and response channels; no dependencies.
`default_nettype none
interface fwr_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [31:0] seq_no;
   logic        sum_present;
   logic [15:0] sent_checksum;
   logic        write_ok;
   logic [31:0] transfer_tag;

   modport source (output valid, op, data_byte, last_byte, seq_no, sum_present,
                   sent_checksum, write_ok, transfer_tag, input ready);
   modport sink   (input valid, op, data_byte, last_byte, seq_no, sum_present,
                   sent_checksum, write_ok, transfer_tag, output ready);
endinterface

interface fwr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        all_received;
   logic [31:0] resend_at;
   logic [31:0] echo_tag;

   modport source (output valid, status, all_received, resend_at, echo_tag, input ready);
   modport sink   (input valid, status, all_received, resend_at, echo_tag, output ready);
endinterface
`default_nettype wire

[rtl/core/fwr_front.sv]
// Front end: accepts request words, counts and checksums message bytes.
// Pushes start and message-end entries to the queue. Uses fwr_pkg, fwr_req_if.
`default_nettype none
module fwr_front import fwr_pkg::*; #(
   parameter int MAX_PACKET_BYTES = FWR_MAX_PACKET_BYTES,
   localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   fwr_req_if.sink               req,
   input  wire logic             q_full,
   output logic                  q_push,
   output logic [CNT_W-1:0]      q_count,
   output fwr_msg_type           q_msg
);

   logic [CNT_W-1:0] count_ff, count_in, count_sat;
   logic [31:0]      sum_ff, sum_in, sum_fin;
   logic [7:0]       high_ff, high_in;
   logic             odd_ff, odd_in;
   logic [15:0]      word;
   logic             accept;
   logic             is_start;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign is_start  = (req.op == FWR_OP_START);

   // count saturates one past the limit
   assign count_sat = (count_ff <= CNT_W'(MAX_PACKET_BYTES)) ? count_ff + 1'b1 : count_ff;
   // an odd tail byte is padded with a zero low byte
   assign word      = odd_ff ? {high_ff, req.data_byte} : {req.data_byte, 8'h00};
   assign sum_fin   = sum_ff + {16'h0000, word};

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      high_in  = high_ff;
      odd_in   = odd_ff;
      if (accept) begin
         if (is_start || req.last_byte) begin
            count_in = '0;
            sum_in   = '0;
            high_in  = '0;
            odd_in   = 1'b0;
         end else begin
            count_in = count_sat;
            if (odd_ff) begin
               sum_in = sum_fin;
               odd_in = 1'b0;
            end else begin
               high_in = req.data_byte;
               odd_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         high_ff  <= '0;
         odd_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
         odd_ff   <= odd_in;
      end
   end

   assign q_push  = accept && (is_start || req.last_byte);
   assign q_count = is_start ? '0 : count_sat;

   always_comb begin
      q_msg.is_start      = is_start;
      q_msg.sum           = sum_fin;
      q_msg.seq_no        = req.seq_no;
      q_msg.sum_present   = req.sum_present;
      q_msg.sent_checksum = req.sent_checksum;
      q_msg.write_ok      = req.write_ok;
      q_msg.transfer_tag  = req.transfer_tag;
   end

endmodule
`default_nettype wire

[rtl/core/fwr_fifo.sv]
// Small flop-based queue between front and back ends.
// Generic width and depth; uses fwr_pkg for the default depth.
`default_nettype none
module fwr_fifo import fwr_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = FWR_QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[rtl/core/fwr_back.sv]
// Back end: transfer state, message checks and the registered response word.
// Uses fwr_pkg and fwr_rsp_if; fed from fwr_fifo.
`default_nettype none
module fwr_back import fwr_pkg::*; #(
   parameter int MAX_PACKET_BYTES = FWR_MAX_PACKET_BYTES,
   localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fwr_cfg_type      cfg,
   input  wire logic             q_valid,
   input  wire logic [CNT_W-1:0] q_count,
   input  wire fwr_msg_type      q_msg,
   output logic                  q_pop,
   fwr_rsp_if.source             rsp
);

   logic           open_ff, open_in;
   logic [31:0]    bytes_done_ff, bytes_done_in;
   logic [31:0]    pos_ff, pos_in;          // start offset, plus the count on errors, twice the count on good messages
   logic [31:0]    expected_ff, expected_in;
   logic [15:0]    until_ack_ff, until_ack_in;
   logic           rsp_valid_ff, rsp_valid_in;
   fwr_status_type status_ff, status_in;
   logic           complete_ff, complete_in;
   logic [31:0]    retry_ff, retry_in;
   logic [31:0]    tag_ff;

   logic [15:0]    eff_rate, until_dec;
   logic [31:0]    n32, n2_32, bytes_new, pos_n, pos_2n, expected_inc;
   logic [16:0]    fold1;
   logic [15:0]    fold2, cksum;
   logic           cksum_bad, emit;

   assign eff_rate     = (cfg.ack_interval == '0) ? FWR_ACK_INTERVAL_DEFAULT : cfg.ack_interval;
   assign n32          = 32'(q_count);
   assign n2_32        = 32'({q_count, 1'b0});
   assign bytes_new    = bytes_done_ff + n32;
   assign pos_n        = pos_ff + n32;
   assign pos_2n       = pos_ff + n2_32;
   assign expected_inc = expected_ff + 32'd1;
   assign until_dec    = (until_ack_ff != '0) ? until_ack_ff - 1'b1 : until_ack_ff;

   assign fold1     = {1'b0, q_msg.sum[15:0]} + {1'b0, q_msg.sum[31:16]};
   assign fold2     = fold1[15:0] + {15'h0000, fold1[16]};
   assign cksum     = ~fold2;
   assign cksum_bad = cfg.check_en && q_msg.sum_present && (cksum != q_msg.sent_checksum);

   assign q_pop = q_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      open_in       = open_ff;
      bytes_done_in = bytes_done_ff;
      pos_in        = pos_ff;
      expected_in   = expected_ff;
      until_ack_in  = until_ack_ff;
      status_in     = FWR_ST_OK;
      complete_in   = 1'b0;
      retry_in      = '0;
      emit          = 1'b0;
      if (q_msg.is_start) begin
         open_in       = 1'b1;
         bytes_done_in = '0;
         pos_in        = cfg.start_offset;
         expected_in   = '0;
         until_ack_in  = eff_rate;
      end else if (!open_ff) begin
         status_in = FWR_ST_BAD_STATE;
         emit      = 1'b1;
      end else if (q_count > CNT_W'(MAX_PACKET_BYTES)) begin
         open_in   = 1'b0;
         status_in = FWR_ST_BAD_SIZE;
         emit      = 1'b1;
      end else begin
         bytes_done_in = bytes_new;
         emit          = 1'b1;
         if (!q_msg.write_ok) begin
            pos_in    = pos_n;
            status_in = FWR_ST_WRITE_FAIL;
         end else begin
            until_ack_in = until_dec;
            expected_in  = expected_inc;
            if (q_msg.seq_no != expected_inc) begin
               pos_in      = pos_n;
               status_in   = FWR_ST_COUNT_ERR;
               retry_in    = pos_n;
               expected_in = q_msg.seq_no;
            end else if (cksum_bad) begin
               pos_in    = pos_n;
               status_in = FWR_ST_CKSUM_ERR;
               retry_in  = pos_n;
            end else begin
               pos_in = pos_2n;
               if (bytes_new >= cfg.total_bytes) begin
                  complete_in = 1'b1;
               end else if (until_dec != '0) begin
                  emit = 1'b0;
               end else begin
                  until_ack_in = eff_rate;
                  expected_in  = '0;
               end
            end
         end
      end
   end

   assign rsp_valid_in = q_pop ? emit : (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         bytes_done_ff <= '0;
         pos_ff        <= '0;
         expected_ff   <= '0;
         until_ack_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            open_ff       <= open_in;
            bytes_done_ff <= bytes_done_in;
            pos_ff        <= pos_in;
            expected_ff   <= expected_in;
            until_ack_ff  <= until_ack_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         status_ff   <= status_in;
         complete_ff <= complete_in;
         retry_ff    <= retry_in;
         tag_ff      <= q_msg.transfer_tag;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.all_received = complete_ff;
   assign rsp.resend_at    = retry_ff;
   assign rsp.echo_tag     = tag_ff;

endmodule
`default_nettype wire

[rtl/core/file_write_receiver_core.sv]
// A message-end entry is written to the queue on the edge that takes the last byte of a message;
// the back end then pops it and registers its response word.
// Throughput: one request word per cycle while the queue is not full; the back end retires one
// queue entry per cycle unless a response waits, and the queue (QUEUE_DEPTH entries) absorbs response-side stalls.
// Reset: synchronous, active high; clears transfer state, counters and queue, and loads
// the register defaults (ack rate ten, others zero). Top level: front, queue, back end.
`default_nettype none
`include "file_write_receiver_core_defines.svh"
module file_write_receiver_core import fwr_pkg::*; #(
   parameter int MAX_PACKET_BYTES = FWR_MAX_PACKET_BYTES,
   parameter int QUEUE_DEPTH      = FWR_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fwr_req_if.sink          req_chan,
   fwr_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
   localparam int Q_W   = CNT_W + FWR_MSG_W;

   fwr_cfg_type      cfg_ff, cfg_in;
   logic             q_push, q_full, q_pop, q_valid;
   logic [CNT_W-1:0] push_count, pop_count;
   fwr_msg_type      push_msg, pop_msg;
   logic [Q_W-1:0]   pop_data;
   logic             start_accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            FWR_CSR_TOTAL_BYTES:  cfg_in.total_bytes  = csr_wdata;
            FWR_CSR_ACK_INTERVAL: cfg_in.ack_interval = csr_wdata[15:0];
            FWR_CSR_CHECK_EN:     cfg_in.check_en     = csr_wdata[0];
            FWR_CSR_START_OFFSET: cfg_in.start_offset = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_bytes  <= FWR_TOTAL_BYTES_RESET;
         cfg_ff.ack_interval <= FWR_ACK_INTERVAL_DEFAULT;
         cfg_ff.check_en     <= 1'b0;
         cfg_ff.start_offset <= FWR_START_OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fwr_front #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_count (push_count),
      .q_msg   (push_msg)
   );

   fwr_fifo #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_count, push_msg}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (pop_data)
   );

   assign pop_count = pop_data[Q_W-1 -: CNT_W];
   assign pop_msg   = pop_data[FWR_MSG_W-1:0];

   fwr_back #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_count (pop_count),
      .q_msg   (pop_msg),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

   assign start_accept = req_chan.valid && req_chan.ready && (req_chan.op == FWR_OP_START);

   `FWR_ASSERT_SAME(a_queue_no_overflow, clock, reset, q_push, !q_full, "queue push while full")
   `FWR_ASSERT_SAME(a_pop_has_entry, clock, reset, q_pop, q_valid, "back end pop from empty queue")
   `FWR_ASSERT_NEXT(a_start_queued, clock, reset, start_accept, q_valid, "start word not queued")

endmodule
`default_nettype wire
